### hw/rtl/rlhs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register indexes for the radio link scheduler
// no dependencies
package rlhs_pkg;

  // default and maximum sizing of the payload ring
  localparam int QUEUE_DEPTH_DEF   = 8;
  localparam int PAYLOAD_BYTES_DEF = 28;
  localparam int QUEUE_DEPTH_MAX   = 64;
  localparam int PAYLOAD_BYTES_MAX = 60;

  // job base address is sized for the largest ring (one spare slot)
  localparam int JOB_ADDR_W = $clog2((QUEUE_DEPTH_MAX + 1) * PAYLOAD_BYTES_MAX);

  // transmit time above this counts as zero
  localparam logic [7:0] TX_CLIP_MS = 8'd100;
  // mask on the length byte of a data frame
  localparam int LEN_MASK = 'h3F;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_HOST = 2'd1;
  localparam logic [1:0] REQ_RX   = 2'd2;
  localparam logic [1:0] REQ_POLL = 2'd3;

  // register indexes
  localparam logic [2:0] REG_SYNC_MODE      = 3'd0;
  localparam logic [2:0] REG_ANSWER_WAIT_MS = 3'd1;
  localparam logic [2:0] REG_SYNC_HOLD_MS   = 3'd2;
  localparam logic [2:0] REG_CODE_NONE      = 3'd3;
  localparam logic [2:0] REG_CODE_ASK       = 3'd4;
  localparam logic [2:0] REG_CODE_ANSWER    = 3'd5;
  localparam logic [2:0] REG_CODE_DATA      = 3'd6;
  localparam logic [2:0] REG_CODE_DATA_PACK = 3'd7;

  // input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] host_byte;
    logic [7:0] rx_type;
    logic [7:0] last_tx_ms;
  } in_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_is_pulse;
    logic       overflow_seen;
  } out_t;

  // configuration registers
  typedef struct packed {
    logic        sync_mode;
    logic [15:0] answer_wait_ms;
    logic [15:0] sync_hold_ms;
    logic [7:0]  code_none;
    logic [7:0]  code_ask;
    logic [7:0]  code_answer;
    logic [7:0]  code_data;
    logic [7:0]  code_data_pack;
  } cfg_t;

  // one frame to send, handed from front to back
  typedef struct packed {
    logic                  is_pulse;
    logic [7:0]            first_byte;
    logic                  ovf;
    logic [JOB_ADDR_W-1:0] base;
  } job_t;

endpackage

### hw/rtl/rlhs_front.sv
`timescale 1ns / 1ps
// front end: accepts request beats, keeps timers and the ring pointers,
// writes host bytes into the payload store and queues frame jobs; uses rlhs_pkg
module rlhs_front #(
  parameter int QUEUE_DEPTH   = rlhs_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = rlhs_pkg::PAYLOAD_BYTES_DEF,
  localparam int SLOTS = QUEUE_DEPTH + 1,
  localparam int AW    = $clog2(SLOTS * PAYLOAD_BYTES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlhs_pkg::in_t       in_data,
  input  rlhs_pkg::cfg_t      cfg,
  output logic                job_push,
  output rlhs_pkg::job_t      job,
  input  logic                job_full,
  input  logic                data_done,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [AW-1:0] PB        = AW'(PAYLOAD_BYTES);
  localparam logic [PW-1:0] FILL_LAST = PW'(PAYLOAD_BYTES - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [SW-1:0] Q_FULL    = SW'(QUEUE_DEPTH);

  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [SW-1:0] count, count_next;
  logic [PW-1:0] fill_pos, fill_pos_next;
  logic          need_answer, need_answer_next;
  logic [15:0]   wait_timer, wait_timer_next;
  logic [15:0]   sync_timer, sync_timer_next;
  logic          overflow_flag, overflow_flag_next;
  logic [1:0]    inflight, inflight_next;

  logic          accept;
  logic [7:0]    tx_clip;
  logic [16:0]   wait_sum;
  logic [15:0]   send_wait;
  logic          push_data;

  // stall polls while the job queue is full, host bytes while a frame is read out
  assign in_stall = (in_data.req_type == rlhs_pkg::REQ_POLL && job_full) ||
                    (in_data.req_type == rlhs_pkg::REQ_HOST && inflight != 2'd0);
  assign accept   = in_valid && !in_stall;

  // wait after a send: clipped transmit time plus one plus answer wait, saturated
  assign tx_clip   = (in_data.last_tx_ms > rlhs_pkg::TX_CLIP_MS) ? 8'd0 : in_data.last_tx_ms;
  assign wait_sum  = 17'(tx_clip) + 17'd1 + 17'(cfg.answer_wait_ms);
  assign send_wait = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];

  // host byte goes straight into the spare slot at the tail
  assign wr_addr = AW'(tail) * PB + AW'(fill_pos);
  assign wr_data = in_data.host_byte;

  // request decode
  always_comb begin
    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    fill_pos_next      = fill_pos;
    need_answer_next   = need_answer;
    wait_timer_next    = wait_timer;
    sync_timer_next    = sync_timer;
    overflow_flag_next = overflow_flag;
    wr_en              = 1'b0;
    job_push           = 1'b0;
    push_data          = 1'b0;
    job.is_pulse       = 1'b0;
    job.first_byte     = cfg.code_data;
    job.ovf            = overflow_flag;
    job.base           = rlhs_pkg::JOB_ADDR_W'(AW'(head) * PB);
    if (accept) begin
      unique case (in_data.req_type)
        rlhs_pkg::REQ_TICK: begin
          if (wait_timer != 16'd0) wait_timer_next = wait_timer - 16'd1;
          if (sync_timer != 16'd0) sync_timer_next = sync_timer - 16'd1;
        end
        rlhs_pkg::REQ_HOST: begin
          wr_en = 1'b1;
          if (fill_pos == FILL_LAST) begin
            fill_pos_next = '0;
            if (count != Q_FULL) begin
              tail_next  = (tail == SLOT_LAST) ? '0 : tail + SW'(1);
              count_next = count + SW'(1);
            end else begin
              overflow_flag_next = 1'b1;
            end
          end else begin
            fill_pos_next = fill_pos + PW'(1);
          end
        end
        rlhs_pkg::REQ_RX: begin
          if (cfg.sync_mode && in_data.rx_type == cfg.code_none) begin
            need_answer_next = 1'b0;
            wait_timer_next  = 16'd0;
          end else if (cfg.sync_mode && in_data.rx_type == cfg.code_ask) begin
            need_answer_next = 1'b1;
            wait_timer_next  = 16'd0;
          end else if (cfg.sync_mode && in_data.rx_type == cfg.code_answer) begin
            need_answer_next = 1'b0;
            wait_timer_next  = 16'd0;
          end else if (in_data.rx_type == cfg.code_data) begin
            need_answer_next = 1'b1;
            wait_timer_next  = 16'd0;
          end else if (in_data.rx_type == cfg.code_data_pack) begin
            need_answer_next = 1'b0;
            wait_timer_next  = cfg.answer_wait_ms;
          end
        end
        rlhs_pkg::REQ_POLL: begin
          if (wait_timer == 16'd0) begin
            if (count != '0) begin
              job_push         = 1'b1;
              push_data        = 1'b1;
              head_next        = (head == SLOT_LAST) ? '0 : head + SW'(1);
              count_next       = count - SW'(1);
              if (cfg.sync_mode) wait_timer_next = send_wait;
              sync_timer_next  = cfg.sync_hold_ms;
              need_answer_next = 1'b0;
            end else if (cfg.sync_mode && (need_answer || sync_timer != 16'd0)) begin
              job_push         = 1'b1;
              job.is_pulse     = 1'b1;
              job.first_byte   = need_answer ? cfg.code_answer : cfg.code_ask;
              need_answer_next = 1'b0;
              wait_timer_next  = send_wait;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // data frames still being read from the store
  always_comb begin
    inflight_next = inflight;
    if (push_data && !data_done) inflight_next = inflight + 2'd1;
    else if (!push_data && data_done) inflight_next = inflight - 2'd1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      fill_pos      <= '0;
      need_answer   <= 1'b0;
      wait_timer    <= 16'd0;
      sync_timer    <= 16'd0;
      overflow_flag <= 1'b0;
      inflight      <= 2'd0;
    end else begin
      head          <= head_next;
      tail          <= tail_next;
      count         <= count_next;
      fill_pos      <= fill_pos_next;
      need_answer   <= need_answer_next;
      wait_timer    <= wait_timer_next;
      sync_timer    <= sync_timer_next;
      overflow_flag <= overflow_flag_next;
      inflight      <= inflight_next;
    end
  end

`ifndef SYNTH
  // the ring never holds more payloads than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_FULL)
    else $error("payload ring count beyond depth");

  // no job is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job pushed into full queue");
`endif

endmodule

### hw/rtl/rlhs_jobq.sv
`timescale 1ns / 1ps
// two-entry job queue between the front and back ends
// uses rlhs_pkg
module rlhs_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlhs_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output rlhs_pkg::job_t head_job,
  input  logic           pop
);

  rlhs_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && head_valid) rd_ptr <= !rd_ptr;
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/rlhs_back.sv
`timescale 1ns / 1ps
// back end: payload store, frame sequencer, read stage and output register
// uses rlhs_pkg
module rlhs_back #(
  parameter int QUEUE_DEPTH   = rlhs_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = rlhs_pkg::PAYLOAD_BYTES_DEF,
  localparam int SLOTS = QUEUE_DEPTH + 1,
  localparam int AW    = $clog2(SLOTS * PAYLOAD_BYTES)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  rlhs_pkg::job_t job,
  output logic           job_pop,
  output logic           data_done,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [7:0]     wr_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlhs_pkg::out_t out_data
);

  localparam int STW = $clog2(PAYLOAD_BYTES + 2);
  localparam logic [STW-1:0] LAST_BEAT = STW'(PAYLOAD_BYTES + 1);
  localparam logic [7:0]     LEN_BYTE  = 8'(PAYLOAD_BYTES & rlhs_pkg::LEN_MASK);

  logic [7:0]     store [SLOTS * PAYLOAD_BYTES];
  logic [7:0]     rdata;

  logic [STW-1:0] beat_idx, beat_idx_next;
  logic           s1_valid;
  logic           s1_mem;
  rlhs_pkg::out_t s1_info;

  logic           s1_take;
  logic           s1_free;
  logic           issue;
  logic           beat_mem;
  rlhs_pkg::out_t beat_info;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  rlhs_pkg::out_t out_next;

  // handshake between stages
  assign s1_take = s1_valid && (!out_valid || !out_stall);
  assign s1_free = !s1_valid || s1_take;
  assign issue   = job_valid && s1_free;

  // beat of the current frame: code, length, then payload bytes; a pulse is its code alone
  always_comb begin
    beat_mem                = 1'b0;
    beat_info.out_byte      = job.first_byte;
    beat_info.out_last      = 1'b0;
    beat_info.out_is_pulse  = job.is_pulse;
    beat_info.overflow_seen = job.ovf;
    if (job.is_pulse) begin
      beat_info.out_last = 1'b1;
    end else if (beat_idx == STW'(1)) begin
      beat_info.out_byte = LEN_BYTE;
      beat_info.out_last = (PAYLOAD_BYTES == 0);
    end else if (beat_idx != '0) begin
      beat_mem           = 1'b1;
      beat_info.out_last = (beat_idx == LAST_BEAT);
    end
  end

  assign rd_en     = issue && beat_mem;
  assign rd_addr   = AW'(job.base) + AW'(beat_idx) - AW'(2);
  assign job_pop   = issue && (job.is_pulse || beat_idx == LAST_BEAT);
  assign data_done = job_pop && !job.is_pulse;

  always_comb begin
    beat_idx_next = beat_idx;
    if (job_pop) beat_idx_next = '0;
    else if (issue) beat_idx_next = beat_idx + STW'(1);
  end

  // payload store: written by the front, read here
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (rd_en) rdata <= store[rd_addr];
  end

  // output beat from the read stage
  always_comb begin
    out_next          = s1_info;
    out_next.out_byte = s1_mem ? rdata : s1_info.out_byte;
  end

  // sequencer, read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      beat_idx <= beat_idx_next;
      if (s1_free) s1_valid <= issue;
      if (s1_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_mem  <= beat_mem;
      s1_info <= beat_info;
    end
    if (s1_take) out_data <= out_next;
  end

`ifndef SYNTH
  // a sync pulse is always a single-beat frame
  a_pulse_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_is_pulse |-> out_data.out_last)
    else $error("pulse beat without last");

  // the read stage holds its beat while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_info))
    else $error("read stage lost a beat under stall");
`endif

endmodule

### hw/rtl/radio_link_handshake_scheduler_top.sv
`timescale 1ns / 1ps
// half-duplex radio link scheduler; after a poll the first frame beat passes the job queue,
// read stage and output register; one request beat a cycle unless stalled; a data frame streams
// PAYLOAD_BYTES+2 beats, one per cycle while the output is not stalled, payload bytes from the
// store read port; pulses are one beat; polls stall while two frames are queued, host bytes
// while a data frame is read out; reset: synchronous, clears timers, pointers and flags,
// registers to defaults; payload store contents undefined until written, no clearing pass
module radio_link_handshake_scheduler_top #(
  parameter int QUEUE_DEPTH   = rlhs_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = rlhs_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlhs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlhs_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int AW = $clog2((QUEUE_DEPTH + 1) * PAYLOAD_BYTES);

  rlhs_pkg::cfg_t cfg;
  logic           cfg_wr;
  logic           job_push;
  rlhs_pkg::job_t push_job;
  logic           job_full;
  logic           job_valid;
  rlhs_pkg::job_t head_job;
  logic           job_pop;
  logic           data_done;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_mode      <= 1'b1;
      cfg.answer_wait_ms <= 16'd50;
      cfg.sync_hold_ms   <= 16'd1000;
      cfg.code_none      <= 8'd0;
      cfg.code_ask       <= 8'd1;
      cfg.code_answer    <= 8'd2;
      cfg.code_data      <= 8'd3;
      cfg.code_data_pack <= 8'd4;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        rlhs_pkg::REG_SYNC_MODE:      cfg.sync_mode      <= pwdata[0];
        rlhs_pkg::REG_ANSWER_WAIT_MS: cfg.answer_wait_ms <= pwdata[15:0];
        rlhs_pkg::REG_SYNC_HOLD_MS:   cfg.sync_hold_ms   <= pwdata[15:0];
        rlhs_pkg::REG_CODE_NONE:      cfg.code_none      <= pwdata[7:0];
        rlhs_pkg::REG_CODE_ASK:       cfg.code_ask       <= pwdata[7:0];
        rlhs_pkg::REG_CODE_ANSWER:    cfg.code_answer    <= pwdata[7:0];
        rlhs_pkg::REG_CODE_DATA:      cfg.code_data      <= pwdata[7:0];
        rlhs_pkg::REG_CODE_DATA_PACK: cfg.code_data_pack <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      rlhs_pkg::REG_SYNC_MODE:      prdata = 32'(cfg.sync_mode);
      rlhs_pkg::REG_ANSWER_WAIT_MS: prdata = 32'(cfg.answer_wait_ms);
      rlhs_pkg::REG_SYNC_HOLD_MS:   prdata = 32'(cfg.sync_hold_ms);
      rlhs_pkg::REG_CODE_NONE:      prdata = 32'(cfg.code_none);
      rlhs_pkg::REG_CODE_ASK:       prdata = 32'(cfg.code_ask);
      rlhs_pkg::REG_CODE_ANSWER:    prdata = 32'(cfg.code_answer);
      rlhs_pkg::REG_CODE_DATA:      prdata = 32'(cfg.code_data);
      rlhs_pkg::REG_CODE_DATA_PACK: prdata = 32'(cfg.code_data_pack);
      default:                      prdata = '0;
    endcase
  end

  // front end
  rlhs_front #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .job_push  (job_push),
    .job       (push_job),
    .job_full  (job_full),
    .data_done (data_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // job queue
  rlhs_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .full       (job_full),
    .head_valid (job_valid),
    .head_job   (head_job),
    .pop        (job_pop)
  );

  // back end
  rlhs_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .data_done (data_done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
